// ===== hw/rtl/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
`default_nettype none

package bpa_pkg;

	localparam int OPC_W     = 2;
	localparam int START_W   = 12;
	localparam int CNT_W     = 13;
	localparam int TOTAL_W   = 13;
	localparam int FOUND_W   = 12;
	localparam int USED_W    = 13;
	localparam int WORD_BITS = 8;
	localparam int WORD_SH   = 3;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;

	localparam logic [USED_W-1:0] USED_MAX = 13'h1FFF;

	typedef enum logic [OPC_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_MARK  = 2'd2,
		OP_QUERY = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		WM_SCAN  = 2'd0,
		WM_SET   = 2'd1,
		WM_CLR   = 2'd2,
		WM_QUERY = 2'd3
	} walk_mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'd0,
		ST_IDLE  = 3'd1,
		ST_PREP  = 3'd2,
		ST_SCAN  = 3'd3,
		ST_CHECK = 3'd4,
		ST_WALK  = 3'd5,
		ST_RESP  = 3'd6
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_go;
		logic walk_go;
		logic fail;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic done;
		logic hit;
		logic alloc_bad;
		logic range_empty;
		logic is_alloc;
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator.sv =====
// Top level of the first-fit bitmap page frame allocator.
//
//  channel | signals                    | contents
//  s       | s_tvalid s_tready          | s_tuser: opcode[1:0]; s_tdata: start_page, page_count
//  m       | m_tvalid m_tready          | m_tdata: ok, found_page, any_used, used_pages
//  cfg     | cfg_valid cfg_ready        | cfg_data: total_pages
//
// After reset the bitmap is zeroed one 8-page row per cycle, with s_tready low until
// the clear ends. Free, mark and query walk the rows the range spans; an empty range
// goes straight to the response. Alloc scans rows from page 0 up to the first fit or
// the limit min(total_pages,PAGES), then marks the run. One item is in flight; the
// result is held in m_tdata until the beat is taken.
`default_nettype none

module bitmap_page_allocator #(
	parameter int PAGES = 4096
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [bpa_pkg::IN_DATA_W-1:0]        s_tdata,  // start_page[11:0], page_count[24:12]
	input  wire [bpa_pkg::OPC_W-1:0]            s_tuser,  // opcode[1:0]
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [bpa_pkg::OUT_DATA_W-1:0]      m_tdata,  // ok[0], found_page[12:1], any_used[13], used_pages[26:14]
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [bpa_pkg::TOTAL_W-1:0]          cfg_data
);
	import bpa_pkg::*;

	cmd_t               cmd;
	status_t            status;
	logic               res_ok;
	logic [FOUND_W-1:0] res_found;
	logic               res_any;
	logic [USED_W-1:0]  res_used;

	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bpa_datapath #(
		.PAGES (PAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.in_opcode (s_tuser),
		.in_start  (s_tdata[START_W-1:0]),
		.in_count  (s_tdata[START_W+CNT_W-1:START_W]),
		.res_ok    (res_ok),
		.res_found (res_found),
		.res_any   (res_any),
		.res_used  (res_used)
	);

	assign m_tdata = {{(OUT_DATA_W - 1 - FOUND_W - 1 - USED_W){1'b0}},
		res_used, res_any, res_found, res_ok};

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_ctrl.sv =====
// Controller state machine for the bitmap page allocator.
`default_nettype none

module bpa_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire               m_tready,
	input  wire bpa_pkg::status_t status,
	output bpa_pkg::cmd_t     cmd
);
	import bpa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (!status.clearing) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_PREP;
			end
			ST_PREP: begin
				if (status.is_alloc) begin
					state_d = status.alloc_bad ? ST_RESP : ST_SCAN;
				end else begin
					state_d = status.range_empty ? ST_RESP : ST_WALK;
				end
			end
			ST_SCAN: begin
				if (status.done) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = status.hit ? ST_WALK : ST_RESP;
			end
			ST_WALK: begin
				if (status.done) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_PREP: begin
				if (status.is_alloc) begin
					cmd.fail    = status.alloc_bad;
					cmd.scan_go = !status.alloc_bad;
				end else begin
					cmd.walk_go = !status.range_empty;
				end
			end
			ST_CHECK: begin
				cmd.walk_go = status.hit;
				cmd.fail    = !status.hit;
			end
			ST_RESP: begin
				m_tvalid = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_datapath.sv =====
// Datapath of the bitmap page allocator: bitmap memory, row walker, counters.
`default_nettype none

module bpa_datapath #(
	parameter int PAGES = 4096
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire bpa_pkg::cmd_t                 cmd,
	output bpa_pkg::status_t                   status,
	input  wire                                cfg_we,
	input  wire [bpa_pkg::TOTAL_W-1:0]         cfg_data,
	input  wire [bpa_pkg::OPC_W-1:0]           in_opcode,
	input  wire [bpa_pkg::START_W-1:0]         in_start,
	input  wire [bpa_pkg::CNT_W-1:0]           in_count,
	output logic                               res_ok,
	output logic [bpa_pkg::FOUND_W-1:0]        res_found,
	output logic                               res_any,
	output logic [bpa_pkg::USED_W-1:0]         res_used
);
	import bpa_pkg::*;

	localparam int ROWS = (PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PV_W = $clog2(PAGES + 1);
	localparam int EW   = ((PV_W > 14) ? PV_W : 14) + 1;
	localparam int CW   = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] bitmap_mem [ROWS];

	logic [TOTAL_W-1:0] total_q;
	opcode_t            op_q;
	logic [START_W-1:0] start_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ok_q;
	logic [EW-1:0]      found_q;
	logic               any_q;
	logic               hit_q;
	logic [PV_W-1:0]    used_q;

	logic               clr_q;
	logic [RW-1:0]      clr_row_q;

	walk_mode_t         mode_q;
	logic               act_q;
	logic [RW-1:0]      rd_row_q;
	logic [RW-1:0]      last_row_q;
	logic [EW-1:0]      lo_q;
	logic [EW-1:0]      hi_q;
	logic [EW-1:0]      run_q;

	logic               v_s1;
	logic [RW-1:0]      row_s1;
	logic               last_s1;
	logic [WORD_BITS-1:0] rdata_s1;

	logic [EW-1:0] cnt_ext;
	logic [EW-1:0] limit;
	logic [EW-1:0] rng_lo;
	logic [EW-1:0] rng_sum;
	logic [EW-1:0] rng_hi;
	logic [EW-1:0] go_lo;
	logic [EW-1:0] go_hi;
	logic [EW-1:0] go_lo_row;
	logic [EW-1:0] go_last_row;
	walk_mode_t    go_mode;

	logic [EW-1:0]        base;
	logic [EW-1:0]        pg;
	logic [EW-1:0]        run;
	logic                 hit;
	logic [EW-1:0]        hit_pg;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] wdata;
	logic [CW-1:0]        flips;
	logic                 modify;
	logic                 fin;

	logic                 mem_we;
	logic [RW-1:0]        mem_wa;
	logic [WORD_BITS-1:0] mem_wd;
	logic [EW-1:0]        used_ext;

	// item bounds
	always_comb begin
		cnt_ext = EW'(cnt_q);
		limit   = (EW'(total_q) > EW'(PAGES)) ? EW'(PAGES) : EW'(total_q);
		rng_lo  = (op_q == OP_ALLOC) ? found_q : EW'(start_q);
		rng_sum = rng_lo + cnt_ext;
		rng_hi  = (rng_sum > EW'(PAGES)) ? EW'(PAGES) : rng_sum;
		if (cmd.scan_go) begin
			go_lo   = '0;
			go_hi   = limit;
			go_mode = WM_SCAN;
		end else begin
			go_lo = rng_lo;
			go_hi = rng_hi;
			case (op_q)
				OP_FREE:  go_mode = WM_CLR;
				OP_QUERY: go_mode = WM_QUERY;
				default:  go_mode = WM_SET;
			endcase
		end
		go_lo_row   = go_lo >> WORD_SH;
		go_last_row = (go_hi - EW'(1)) >> WORD_SH;
	end

	// per-row work at stage 1
	always_comb begin
		base   = EW'(row_s1) << WORD_SH;
		run    = run_q;
		hit    = 1'b0;
		hit_pg = '0;
		mask   = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			pg      = base + EW'(j);
			mask[j] = (pg >= lo_q) && (pg < hi_q);
			if (pg < hi_q) begin
				if (rdata_s1[j]) begin
					run = '0;
				end else begin
					run = run + EW'(1);
				end
				if (!hit && run == cnt_ext) begin
					hit    = 1'b1;
					hit_pg = pg + EW'(1) - cnt_ext;
				end
			end
		end
		case (mode_q)
			WM_SET: begin
				wdata = rdata_s1 | mask;
				flips = CW'($countones(mask & ~rdata_s1));
			end
			WM_CLR: begin
				wdata = rdata_s1 & ~mask;
				flips = CW'($countones(mask & rdata_s1));
			end
			default: begin
				wdata = rdata_s1;
				flips = '0;
			end
		endcase
		modify = v_s1 && (mode_q == WM_SET || mode_q == WM_CLR);
		fin    = v_s1 && (last_s1 || (mode_q == WM_SCAN && hit));
	end

	always_comb begin
		mem_we = clr_q || modify;
		mem_wa = clr_q ? clr_row_q : row_s1;
		mem_wd = clr_q ? '0 : wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_we) bitmap_mem[mem_wa] <= mem_wd;
		rdata_s1 <= bitmap_mem[rd_row_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			if (clr_row_q == RW'(ROWS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_row_q <= clr_row_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			v_s1    <= 1'b0;
			used_q  <= '0;
			mode_q  <= WM_SCAN;
		end else begin
			if (cmd.scan_go || cmd.walk_go) begin
				act_q  <= 1'b1;
				mode_q <= go_mode;
				v_s1   <= 1'b0;
			end else if (fin) begin
				act_q <= 1'b0;
				v_s1  <= 1'b0;
			end else begin
				v_s1 <= act_q;
				if (act_q && rd_row_q == last_row_q) act_q <= 1'b0;
			end
			if (modify) begin
				if (mode_q == WM_SET) begin
					used_q <= used_q + PV_W'(flips);
				end else begin
					used_q <= used_q - PV_W'(flips);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode_t'(in_opcode);
			start_q <= in_start;
			cnt_q   <= in_count;
			ok_q    <= 1'b1;
			found_q <= '0;
			any_q   <= 1'b0;
			hit_q   <= 1'b0;
		end
		if (cmd.fail) ok_q <= 1'b0;
		if (cmd.scan_go || cmd.walk_go) begin
			rd_row_q   <= go_lo_row[RW-1:0];
			last_row_q <= go_last_row[RW-1:0];
			lo_q       <= go_lo;
			hi_q       <= go_hi;
			run_q      <= '0;
		end else begin
			if (act_q) rd_row_q <= rd_row_q + RW'(1);
			row_s1  <= rd_row_q;
			last_s1 <= (rd_row_q == last_row_q);
			if (v_s1) begin
				run_q <= run;
				if (mode_q == WM_QUERY && |(rdata_s1 & mask)) any_q <= 1'b1;
				if (mode_q == WM_SCAN && hit) begin
					hit_q   <= 1'b1;
					found_q <= hit_pg;
				end
			end
		end
	end

	always_comb begin
		used_ext           = EW'(used_q);
		status.clearing    = clr_q;
		status.done        = fin;
		status.hit         = hit_q;
		status.alloc_bad   = (cnt_q == '0) || (cnt_ext > limit);
		status.range_empty = (rng_hi <= rng_lo);
		status.is_alloc    = (op_q == OP_ALLOC);
		res_ok             = ok_q;
		res_found          = found_q[FOUND_W-1:0];
		res_any            = any_q;
		res_used           = (used_ext > EW'(USED_MAX)) ? USED_MAX : used_ext[USED_W-1:0];
	end

endmodule

`default_nettype wire
